@@ rtl/core/mrr_pkg.sv @@
// ----------------------------------------------------------------------------
// mrr_pkg
// Types, codes and the CRC-16 byte update for the Modbus RTU response receiver.
// ----------------------------------------------------------------------------
package mrr_pkg;

	// request types
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// frame status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_CRC_ERR  = 2'd1;
	localparam logic [1:0] ST_TIMEOUT  = 2'd2;
	localparam logic [1:0] ST_CNT_ERR  = 2'd3;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [8:0]  MIN_FRAME_LEN = 9'd5;
	localparam logic [3:0]  RETRY_RESET   = 4'd4;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
		logic [7:0] expected_count;
	} req_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] data_byte;
		logic [7:0] payload_index;
		logic [1:0] frame_status;
		logic [7:0] responder_address;
		logic [7:0] function_code;
		logic [8:0] frame_length;
	} rsp_t;

	// reflected CRC-16, one byte, LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/core/mrr_req_if.sv @@
// ----------------------------------------------------------------------------
// mrr_req_if
// Request channel: valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface mrr_req_if import mrr_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mrr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mrr_rsp_if
// Result channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface mrr_rsp_if import mrr_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mrr_frame.sv @@
// ----------------------------------------------------------------------------
// mrr_frame
// Frame state and its per-request update: CRC, byte position, saved header
// fields, retry count and result formation for one request item.
// ----------------------------------------------------------------------------
module mrr_frame import mrr_pkg::*; #(
	parameter int FRAME_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  req_t       item,
	input  logic [3:0] retry_limit,
	output logic       emit,
	output rsp_t       res
);

	localparam logic [8:0] FrameLimit = 9'(FRAME_BYTES);

	logic [15:0] crc_q,   crc_d;
	logic [8:0]  br_q,    br_d;
	logic [8:0]  tgt_q,   tgt_d;
	logic [3:0]  tmo_q,   tmo_d;
	logic        active_q, active_d;
	logic [7:0]  addr_q,  addr_d;
	logic [7:0]  func_q,  func_d;
	logic [7:0]  cnt_q,   cnt_d;
	logic [7:0]  want_q,  want_d;
	logic [7:0]  crclo_q, crclo_d;

	logic [9:0]  pos_p2;
	logic [8:0]  br_inc;
	logic [3:0]  tmo_inc;
	logic        byte_ok;
	logic [15:0] crc_got;

	assign pos_p2  = {1'b0, br_q} + 10'd2;
	assign br_inc  = br_q + 9'd1;
	assign tmo_inc = tmo_q + 4'd1;
	assign byte_ok = active_q && (br_q < tgt_q) && (br_q < FrameLimit);
	assign crc_got = {item.rx_byte, crclo_q};

	always_comb begin
		crc_d    = crc_q;
		br_d     = br_q;
		tgt_d    = tgt_q;
		tmo_d    = tmo_q;
		active_d = active_q;
		addr_d   = addr_q;
		func_d   = func_q;
		cnt_d    = cnt_q;
		want_d   = want_q;
		crclo_d  = crclo_q;
		emit     = 1'b0;
		res      = '0;
		res.responder_address = addr_q;
		res.function_code     = func_q;
		res.frame_length      = br_q;

		unique case (item.req_type)
			REQ_START: begin
				crc_d    = CRC_INIT;
				br_d     = '0;
				tgt_d    = MIN_FRAME_LEN;
				tmo_d    = '0;
				active_d = 1'b1;
				addr_d   = '0;
				func_d   = '0;
				cnt_d    = '0;
				want_d   = item.expected_count;
				crclo_d  = '0;
			end
			REQ_TICK: begin
				if (active_q) begin
					tmo_d = tmo_inc;
					if (tmo_inc >= retry_limit) begin
						active_d         = 1'b0;
						emit             = 1'b1;
						res.result_kind  = KIND_STATUS;
						res.frame_status = ST_TIMEOUT;
					end
				end
			end
			REQ_BYTE: begin
				if (byte_ok) begin
					br_d             = br_inc;
					res.frame_length = br_inc;
					if (pos_p2 < {1'b0, tgt_q}) begin
						crc_d = crc16_byte(crc_q, item.rx_byte);
						if (br_q == 9'd0) begin
							addr_d = item.rx_byte;
						end else if (br_q == 9'd1) begin
							func_d = item.rx_byte;
						end else if (br_q == 9'd2) begin
							cnt_d = item.rx_byte;
							tgt_d = MIN_FRAME_LEN + {1'b0, item.rx_byte};
						end else begin
							emit              = 1'b1;
							res.result_kind   = KIND_PAYLOAD;
							res.data_byte     = item.rx_byte;
							res.payload_index = 8'(br_q - 9'd3);
						end
					end else if (pos_p2 == {1'b0, tgt_q}) begin
						crclo_d = item.rx_byte;
					end else begin
						// CRC high byte closes the frame
						active_d        = 1'b0;
						emit            = 1'b1;
						res.result_kind = KIND_STATUS;
						if (crc_got != crc_q) begin
							res.frame_status = ST_CRC_ERR;
						end else if (cnt_q != want_q) begin
							res.frame_status = ST_CNT_ERR;
						end else begin
							res.frame_status = ST_OK;
						end
					end
				end
			end
			default: begin
				// unused request type: drop
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_INIT;
			br_q     <= '0;
			tgt_q    <= MIN_FRAME_LEN;
			tmo_q    <= '0;
			active_q <= 1'b0;
			addr_q   <= '0;
			func_q   <= '0;
			cnt_q    <= '0;
			want_q   <= '0;
			crclo_q  <= '0;
		end else if (step) begin
			crc_q    <= crc_d;
			br_q     <= br_d;
			tgt_q    <= tgt_d;
			tmo_q    <= tmo_d;
			active_q <= active_d;
			addr_q   <= addr_d;
			func_q   <= func_d;
			cnt_q    <= cnt_d;
			want_q   <= want_d;
			crclo_q  <= crclo_d;
		end
	end

endmodule

@@ rtl/core/modbus_rtu_response_receiver_top.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_response_receiver_top
// Modbus RTU response receiver: checks one response frame byte by byte,
// forwards payload bytes and reports the final frame status.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   valid/ready        req_type, rx_byte, expected_count
//  rsp      out  valid/ready        result_kind .. frame_length
//  cfg      in   cfg_wr_en          cfg_wr_data = retry_limit
//
//  One request per cycle unless a full result register holds the request
//  stage. The byte-wide CRC update and frame bookkeeping run combinationally
//  between the request register and the result register.
//  A full result register that is not taken holds the request stage.
//  Reset clears the frame state (CRC 0xFFFF, expected length 5) and sets retry_limit 4.
// ----------------------------------------------------------------------------
module modbus_rtu_response_receiver_top import mrr_pkg::*; #(
	parameter int FRAME_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	mrr_req_if.sink    req,
	mrr_rsp_if.source  rsp,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data
);

	logic [3:0] retry_limit_q;
	logic       valid_s1;
	req_t       item_s1;
	logic       rsp_valid_q;
	rsp_t       rsp_data_q;
	logic       advance;
	logic       step;
	logic       emit;
	rsp_t       res;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign step      = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_RESET;
		end else if (cfg_wr_en) begin
			retry_limit_q <= cfg_wr_data;
		end
	end

	// request stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
	end

	mrr_frame #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.item        (item_s1),
		.retry_limit (retry_limit_q),
		.emit        (emit),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			rsp_data_q <= res;
		end
	end

`ifndef ASSERT_OFF
	a_result_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !$past(rsp_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a processed request");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("stalled request lost");

	a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> rsp_valid_q && !rsp.ready && valid_s1)
		else $error("request ready dropped without a stall");
`endif

endmodule

@@ test/mrr_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrr_frame_checker
// Watches the request and result channels of the Modbus RTU response
// receiver, predicts every result from the accepted requests and compares
// each accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mrr_frame_checker import mrr_pkg::*; #(
	parameter int FRAME_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	mrr_req_if         req,
	mrr_rsp_if         rsp,
	input  logic       cfg_wr_en,
	input  logic [3:0] cfg_wr_data,
	output int         err_count,
	output int         pending
);

	// frame state as the block should hold it
	logic [15:0] crc_acc;
	logic [8:0]  rx_len;
	logic [8:0]  want_len;
	logic [3:0]  tick_cnt;
	logic        in_frame;
	logic [7:0]  addr_r;
	logic [7:0]  func_r;
	logic [7:0]  count_r;
	logic [7:0]  wanted_r;
	logic [7:0]  crc_lo_r;
	logic [3:0]  limit_r;

	rsp_t due_results[$];
	int   errs = 0;
	int   waiting = 0;

	assign err_count = errs;
	assign pending = waiting;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic void clear_frame();
		crc_acc = CRC_INIT;
		rx_len = '0;
		want_len = MIN_FRAME_LEN;
		tick_cnt = '0;
		in_frame = 1'b0;
		addr_r = '0;
		func_r = '0;
		count_r = '0;
		wanted_r = '0;
		crc_lo_r = '0;
	endfunction

	function automatic rsp_t pack_result(input logic kind, input logic [7:0] data,
			input logic [7:0] idx, input logic [1:0] status);
		rsp_t r;
		r.result_kind = kind;
		r.data_byte = data;
		r.payload_index = idx;
		r.frame_status = status;
		r.responder_address = addr_r;
		r.function_code = func_r;
		r.frame_length = rx_len;
		return r;
	endfunction

	// Advance the frame by one request; returns 1 when a result is due.
	function automatic logic advance_frame(input req_t item, output rsp_t res);
		logic [8:0] pos;
		logic [1:0] status;
		res = '0;
		case (item.req_type)
			REQ_START: begin
				clear_frame();
				wanted_r = item.expected_count;
				in_frame = 1'b1;
				return 1'b0;
			end
			REQ_TICK: begin
				if (!in_frame) begin
					return 1'b0;
				end
				tick_cnt = tick_cnt + 4'd1;
				if (tick_cnt >= limit_r) begin
					in_frame = 1'b0;
					res = pack_result(KIND_STATUS, 8'h00, 8'h00, ST_TIMEOUT);
					return 1'b1;
				end
				return 1'b0;
			end
			REQ_BYTE: begin
				if (!in_frame || rx_len >= want_len || rx_len >= FRAME_BYTES) begin
					return 1'b0;
				end
				pos = rx_len;
				rx_len = rx_len + 9'd1;
				if (pos + 2 < want_len) begin
					crc_acc = crc16_step(crc_acc, item.rx_byte);
					case (pos)
						9'd0: addr_r = item.rx_byte;
						9'd1: func_r = item.rx_byte;
						9'd2: begin
							count_r = item.rx_byte;
							want_len = MIN_FRAME_LEN + {1'b0, item.rx_byte};
						end
						default: begin
							res = pack_result(KIND_PAYLOAD, item.rx_byte, 8'(pos - 9'd3), ST_OK);
							return 1'b1;
						end
					endcase
					return 1'b0;
				end
				if (pos + 2 == want_len) begin
					crc_lo_r = item.rx_byte;
					return 1'b0;
				end
				// high CRC byte closes the frame; a CRC error outranks a count error
				in_frame = 1'b0;
				if ({item.rx_byte, crc_lo_r} != crc_acc) begin
					status = ST_CRC_ERR;
				end else if (count_r != wanted_r) begin
					status = ST_CNT_ERR;
				end else begin
					status = ST_OK;
				end
				res = pack_result(KIND_STATUS, 8'h00, 8'h00, status);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic check_field(input string field, input logic [15:0] want_v,
			input logic [15:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", field, want_v, got_v);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		rsp_t res;
		if (!arst_n) begin
			clear_frame();
			limit_r = RETRY_RESET;
			due_results.delete();
			waiting <= 0;
		end else begin
			if (cfg_wr_en) begin
				limit_r = cfg_wr_data;
			end
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$error("result with nothing expected: kind %0d status %0d length %0d",
						rsp.data.result_kind, rsp.data.frame_status, rsp.data.frame_length);
					errs++;
				end else begin
					want = due_results.pop_front();
					check_field("result_kind", want.result_kind, rsp.data.result_kind);
					check_field("data_byte", want.data_byte, rsp.data.data_byte);
					check_field("payload_index", want.payload_index, rsp.data.payload_index);
					check_field("frame_status", want.frame_status, rsp.data.frame_status);
					check_field("responder_address", want.responder_address,
						rsp.data.responder_address);
					check_field("function_code", want.function_code, rsp.data.function_code);
					check_field("frame_length", want.frame_length, rsp.data.frame_length);
				end
			end
			if (req.valid && req.ready) begin
				if (advance_frame(req.data, res)) begin
					due_results.push_back(res);
				end
			end
			waiting <= due_results.size();
		end
	end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives whole and broken Modbus RTU response frames, timeout ticks and
// stray requests into the receiver under random idling on both channels,
// across several retry limits, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top import mrr_pkg::*; ();

	localparam int FRAME_BYTES = 256;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef enum int {
		FR_CLEAN,
		FR_BAD_CRC,
		FR_BAD_COUNT,
		FR_BAD_BOTH,
		FR_TIMEOUT,
		FR_ABORT
	} frame_kind_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [3:0] cfg_wr_data = '0;
	logic [3:0] retry_lim = RETRY_RESET;
	int         err_count;
	int         pending;
	int         req_idle_pct = 33;
	int         rsp_idle_pct = 60;
	int         items_sent = 0;
	int         hold_left = 0;
	int         holds_asked = 0;
	int         holds_taken = 0;

	mrr_req_if req_ch ();
	mrr_rsp_if rsp_ch ();

	modbus_rtu_response_receiver_top #(
		.FRAME_BYTES(FRAME_BYTES)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	mrr_frame_checker #(
		.FRAME_BYTES(FRAME_BYTES)
	) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.err_count  (err_count),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	// result side: random stalls, plus a long hold-off whenever one is asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (holds_taken != holds_asked) begin
			holds_taken <= holds_taken + 1;
			hold_left <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
		end
	end

	task automatic push_req(input logic [1:0] kind, input logic [7:0] b, input logic [7:0] cnt);
		while ($urandom_range(99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= '{req_type: kind, rx_byte: b, expected_count: cnt};
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
	endtask

	function automatic logic [15:0] wire_crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) begin
			c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
		end
		return c;
	endfunction

	// Build one frame, open it with a start and send its first n_send bytes.
	task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
			input logic [7:0] count, input logic [7:0] wanted, input logic [15:0] crc_flip,
			input int n_send, input bit noisy, output int ticks);
		logic [7:0]  fb[$];
		logic [15:0] crc;
		fb.push_back(addr);
		fb.push_back(func);
		fb.push_back(count);
		repeat (count) fb.push_back(8'($urandom));
		crc = CRC_INIT;
		foreach (fb[i]) crc = wire_crc_step(crc, fb[i]);
		crc = crc ^ crc_flip;
		fb.push_back(crc[7:0]);
		fb.push_back(crc[15:8]);
		ticks = 0;
		push_req(REQ_START, 8'($urandom), wanted);
		for (int i = 0; i < n_send && i < fb.size(); i++) begin
			// stay one tick short of the limit inside the frame
			if (noisy && $urandom_range(9) == 0 && ticks + 1 < retry_lim) begin
				push_req(REQ_TICK, 8'($urandom), 8'($urandom));
				ticks++;
			end
			if (noisy && $urandom_range(19) == 0) begin
				push_req(REQ_UNUSED, 8'($urandom), 8'($urandom));
			end
			push_req(REQ_BYTE, fb[i], 8'($urandom));
		end
	endtask

	task automatic close_by_ticks(input int ticks);
		int n;
		n = (retry_lim == 0) ? 1 : retry_lim - ticks;
		repeat (n) push_req(REQ_TICK, 8'($urandom), 8'($urandom));
	endtask

	task automatic random_frame();
		logic [7:0]  count;
		logic [7:0]  wanted;
		logic [15:0] flip;
		int          len;
		int          n_send;
		int          ticks;
		frame_kind_t kind;
		count = ($urandom_range(19) == 0) ? 8'($urandom_range(40, 7)) : 8'($urandom_range(6));
		case ($urandom_range(9))
			5: kind = FR_BAD_CRC;
			6: kind = FR_BAD_COUNT;
			7: kind = FR_BAD_BOTH;
			8: kind = FR_TIMEOUT;
			9: kind = FR_ABORT;
			default: kind = FR_CLEAN;
		endcase
		len = count + 5;
		flip = (kind == FR_BAD_CRC || kind == FR_BAD_BOTH) ?
			16'(1 << $urandom_range(15)) : 16'h0000;
		wanted = (kind == FR_BAD_COUNT || kind == FR_BAD_BOTH) ?
			(count ^ 8'(1 << $urandom_range(7))) : count;
		n_send = (kind == FR_TIMEOUT || kind == FR_ABORT) ? $urandom_range(len - 1) : len;
		send_frame(8'($urandom), 8'($urandom), count, wanted, flip, n_send,
			$urandom_range(2) == 0, ticks);
		if (kind == FR_TIMEOUT) begin
			close_by_ticks(ticks);
		end else if (kind != FR_ABORT && $urandom_range(4) == 0) begin
			// stray traffic after the frame has closed
			push_req($urandom_range(1) ? REQ_BYTE : REQ_TICK, 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic run_frames(input int budget);
		int first;
		first = items_sent;
		while (items_sent - first < budget) random_frame();
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_limit(input logic [3:0] value);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		retry_lim = value;
	endtask

	initial begin
		int ticks;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// requests with no frame open are dropped
		push_req(REQ_BYTE, 8'hFF, 8'hFF);
		push_req(REQ_TICK, 8'h00, 8'h00);
		push_req(REQ_UNUSED, 8'hFF, 8'hFF);
		// empty payload, good frame
		send_frame(8'hFF, 8'h00, 8'd0, 8'd0, 16'h0000, 5, 1'b0, ticks);
		// bad CRC and bad count together
		send_frame(8'h00, 8'hFF, 8'd0, 8'hFF, 16'h8000, 5, 1'b0, ticks);
		// count mismatch with one payload byte
		send_frame(8'h5A, 8'h03, 8'd1, 8'd2, 16'h0000, 6, 1'b0, ticks);
		// dropped by the next start, which then times out
		send_frame(8'hA5, 8'h10, 8'd2, 8'd2, 16'h0000, 1, 1'b0, ticks);
		send_frame(8'h3C, 8'h7F, 8'd2, 8'd2, 16'h0000, 2, 1'b0, ticks);
		close_by_ticks(ticks);

		// limit of zero: first tick times out
		set_limit(4'd0);
		repeat (4) random_frame();

		set_limit(4'd1);
		holds_asked <= holds_asked + 1;
		run_frames(80);

		set_limit(4'd15);
		req_idle_pct = 60;
		rsp_idle_pct = 33;
		holds_asked <= holds_asked + 1;
		run_frames(80);

		set_limit(4'($urandom_range(14, 2)));
		req_idle_pct = 0;
		rsp_idle_pct = 0;
		holds_asked <= holds_asked + 1;
		// largest frame that still fits, then one that overruns and must time out
		send_frame(8'($urandom), 8'($urandom), 8'd251, 8'd251, 16'h0000, 256, 1'b0, ticks);
		send_frame(8'($urandom), 8'($urandom), 8'd255, 8'd255, 16'h0000, 260, 1'b1, ticks);
		close_by_ticks(ticks);
		run_frames(60);

		settle();
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/mrr_pkg.sv
rtl/core/mrr_req_if.sv
rtl/core/mrr_rsp_if.sv
rtl/core/mrr_frame.sv
rtl/core/modbus_rtu_response_receiver_top.sv
test/mrr_frame_checker.sv
test/tb_top.sv
